/* rtl/core/jse_pkg.sv */
`default_nettype none

package jse_pkg;

    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic CFG_SIMPLE_MODE       = 1'b0;
    localparam logic CFG_UNESCAPED_UNICODE = 1'b1;

    // characters used by the encoder
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_HEXA10 = 8'h57;

    // control bytes with a short escape
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TOP = 8'h20;

    localparam logic [7:0]  LEAD_TOO_LONG = 8'hF8;
    localparam logic [7:0]  LEAD_FOUR     = 8'hF0;
    localparam logic [7:0]  LEAD_THREE    = 8'hE0;
    localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;
    localparam logic [20:0] CP_MAX        = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_FIRST = 21'h00D800;
    localparam logic [20:0] CP_SURR_LAST  = 21'h00DFFF;
    localparam logic [15:0] SURR_HIGH     = 16'hD800;
    localparam logic [15:0] SURR_LOW      = 16'hDC00;

    typedef enum logic [1:0] {
        JOB_RAW,
        JOB_ESC,
        JOB_UESC,
        JOB_NULL
    } job_kind_t;

    // output work for one input beat
    typedef struct packed {
        logic        open_q;
        job_kind_t   kind;
        logic [3:0]  body_len;
        logic [31:0] data;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CH_DIGIT0 + {4'h0, nib};
        end
        return CH_HEXA10 + {4'h0, nib};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/jse_front.sv */
`default_nettype none

module jse_front import jse_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       simple_mode,
    input  wire logic       unescaped_unicode,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       in_cmd,
    input  wire logic [7:0] in_byte,
    output logic            push_valid,
    input  wire logic       push_ready,
    output job_t            push_job
);

    logic        string_open_reg, string_open_next;
    logic        discarding_reg, discarding_next;
    logic [23:0] pending_reg, pending_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [2:0]  seq_len_reg, seq_len_next;

    logic        accept;
    job_t        job;
    job_t        seq_job;
    logic        seq_fail;

    logic [7:0]  lead, cont1, cont2;
    logic [20:0] cp;
    logic [20:0] cp_off;
    logic        overlong;
    logic [31:0] raw_data;

    function automatic job_t ascii_job(input logic [7:0] b, input logic simple);
        job_t j;
        j          = '0;
        j.kind     = JOB_ESC;
        j.body_len = 4'd2;
        j.data     = {24'h0, b};
        case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: j.data = {24'h0, b};
            CTL_BS:  j.data = {24'h0, CH_B};
            CTL_FF:  j.data = {24'h0, CH_F};
            CTL_LF:  j.data = {24'h0, CH_N};
            CTL_CR:  j.data = {24'h0, CH_R};
            CTL_TAB: j.data = {24'h0, CH_T};
            default:
            begin
                if (b < CTL_TOP)
                begin
                    j.kind     = JOB_UESC;
                    j.body_len = simple ? 4'd0 : 4'd6;
                end
                else
                begin
                    j.kind     = JOB_RAW;
                    j.body_len = 4'd1;
                end
            end
        endcase
        return j;
    endfunction

    assign accept     = in_valid && in_ready;
    assign in_ready   = push_ready;
    assign push_valid = accept && (job.open_q || (job.body_len != 4'd0));
    assign push_job   = job;

    // sequence completion: pending bytes plus this continuation byte
    always_comb
    begin
        lead  = pending_reg[7:0];
        cont1 = 8'h00;
        cont2 = 8'h00;
        case (pend_cnt_reg)
            2'd2:
            begin
                lead  = pending_reg[15:8];
                cont1 = pending_reg[7:0];
            end
            2'd3:
            begin
                lead  = pending_reg[23:16];
                cont1 = pending_reg[15:8];
                cont2 = pending_reg[7:0];
            end
            default: lead = pending_reg[7:0];
        endcase

        case (pend_cnt_reg)
            2'd2:
            begin
                overlong = (lead[3:0] == 4'h0) && !cont1[5];
                cp       = {5'h0, lead[3:0], cont1[5:0], in_byte[5:0]};
                raw_data = {8'h0, in_byte, cont1, lead};
            end
            2'd3:
            begin
                overlong = (lead[2:0] == 3'h0) && (cont1[5:4] == 2'b00);
                cp       = {lead[2:0], cont1[5:0], cont2[5:0], in_byte[5:0]};
                raw_data = {in_byte, cont2, cont1, lead};
            end
            default:
            begin
                overlong = (lead[4:1] == 4'h0);
                cp       = {10'h0, lead[4:0], in_byte[5:0]};
                raw_data = {16'h0, in_byte, lead};
            end
        endcase

        cp_off   = cp - CP_SUPP_BASE;
        seq_job  = '0;
        seq_fail = 1'b0;
        if (overlong)
        begin
            seq_fail = 1'b1;
        end
        else if (unescaped_unicode)
        begin
            seq_job.kind     = JOB_RAW;
            seq_job.body_len = {2'b00, pend_cnt_reg} + 4'd1;
            seq_job.data     = raw_data;
        end
        else if (cp < CP_SUPP_BASE)
        begin
            if ((cp >= CP_SURR_FIRST) && (cp <= CP_SURR_LAST))
            begin
                seq_fail = 1'b1;
            end
            else
            begin
                seq_job.kind     = JOB_UESC;
                seq_job.body_len = 4'd6;
                seq_job.data     = {16'h0, cp[15:0]};
            end
        end
        else if (cp <= CP_MAX)
        begin
            // surrogate pair, high half first
            seq_job.kind     = JOB_UESC;
            seq_job.body_len = 4'd12;
            seq_job.data     = {SURR_LOW | {6'h0, cp_off[9:0]}, SURR_HIGH | {6'h0, cp_off[19:10]}};
        end
        else
        begin
            seq_fail = 1'b1;
        end
    end

    always_comb
    begin
        job              = '0;
        string_open_next = 1'b1;
        discarding_next  = discarding_reg;
        pending_next     = pending_reg;
        pend_cnt_next    = pend_cnt_reg;
        seq_len_next     = seq_len_reg;

        if (in_cmd)
        begin
            if (!discarding_reg)
            begin
                if ((pend_cnt_reg != 2'd0) && !simple_mode)
                begin
                    job.kind     = JOB_NULL;
                    job.body_len = 4'd4;
                end
                else
                begin
                    job.kind     = JOB_RAW;
                    job.body_len = 4'd1;
                    job.data     = {24'h0, CH_QUOTE};
                end
            end
            string_open_next = 1'b0;
            discarding_next  = 1'b0;
            pending_next     = '0;
            pend_cnt_next    = '0;
            seq_len_next     = '0;
        end
        else if (!discarding_reg)
        begin
            if (simple_mode)
            begin
                job           = ascii_job(in_byte, 1'b1);
                pending_next  = '0;
                pend_cnt_next = '0;
                seq_len_next  = '0;
            end
            else if (pend_cnt_reg == 2'd0)
            begin
                if (!in_byte[7])
                begin
                    job = ascii_job(in_byte, 1'b0);
                end
                else if (!in_byte[6] || (in_byte >= LEAD_TOO_LONG))
                begin
                    job.kind        = JOB_NULL;
                    job.body_len    = 4'd4;
                    discarding_next = 1'b1;
                end
                else
                begin
                    pending_next  = {16'h0, in_byte};
                    pend_cnt_next = 2'd1;
                    seq_len_next  = (in_byte >= LEAD_FOUR)  ? 3'd4 :
                                    (in_byte >= LEAD_THREE) ? 3'd3 : 3'd2;
                end
            end
            else if (in_byte[7:6] != 2'b10)
            begin
                job.kind        = JOB_NULL;
                job.body_len    = 4'd4;
                discarding_next = 1'b1;
                pending_next    = '0;
                pend_cnt_next   = '0;
                seq_len_next    = '0;
            end
            else if ((({1'b0, pend_cnt_reg} + 3'd1) < seq_len_reg) && (pend_cnt_reg != 2'd3))
            begin
                pending_next  = {pending_reg[15:0], in_byte};
                pend_cnt_next = pend_cnt_reg + 2'd1;
            end
            else
            begin
                if (seq_fail)
                begin
                    job.kind        = JOB_NULL;
                    job.body_len    = 4'd4;
                    discarding_next = 1'b1;
                end
                else
                begin
                    job = seq_job;
                end
                pending_next  = '0;
                pend_cnt_next = '0;
                seq_len_next  = '0;
            end
        end
        job.open_q = !string_open_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_open_reg <= 1'b0;
            discarding_reg  <= 1'b0;
            pending_reg     <= '0;
            pend_cnt_reg    <= '0;
            seq_len_reg     <= '0;
        end
        else if (accept)
        begin
            string_open_reg <= string_open_next;
            discarding_reg  <= discarding_next;
            pending_reg     <= pending_next;
            pend_cnt_reg    <= pend_cnt_next;
            seq_len_reg     <= seq_len_next;
        end
    end

    a_disc_open: assert property (@(posedge clk) disable iff (!rst_n)
        discarding_reg |-> string_open_reg)
        else $error("discarding outside an open string");

    a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_cnt_reg != 2'd0) |-> (string_open_reg && !discarding_reg))
        else $error("sequence pending while closed or discarding");

    a_pend_len: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_cnt_reg != 2'd0) |-> ({1'b0, pend_cnt_reg} < seq_len_reg))
        else $error("pending count reached sequence length");

endmodule

`default_nettype wire

/* rtl/core/jse_queue.sv */
`default_nettype none

module jse_queue import jse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/jse_back.sv */
`default_nettype none

module jse_back import jse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    output logic      job_ready,
    input  wire job_t job,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    logic [3:0] idx_reg, idx_next;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_err_reg;
    logic       m_last_reg;

    logic       fire;
    logic       last;
    logic [3:0] total_len;
    logic [3:0] body_idx;
    logic [3:0] sub;
    logic [15:0] half;
    logic [7:0] byte_out;
    logic       err_out;

    assign total_len = {3'b000, job.open_q} + job.body_len;
    assign body_idx  = idx_reg - {3'b000, job.open_q};
    assign last      = (idx_reg == (total_len - 4'd1));
    assign fire      = job_valid && (!m_valid_reg || m_tready);
    assign job_ready = fire && last;

    always_comb
    begin
        sub      = (body_idx >= 4'd6) ? body_idx - 4'd6 : body_idx;
        half     = (body_idx >= 4'd6) ? job.data[31:16] : job.data[15:0];
        byte_out = CH_QUOTE;
        err_out  = 1'b0;
        if (!(job.open_q && (idx_reg == 4'd0)))
        begin
            case (job.kind)
                JOB_RAW: byte_out = job.data[8*body_idx[1:0] +: 8];
                JOB_ESC: byte_out = (body_idx == 4'd0) ? CH_BSLASH : job.data[7:0];
                JOB_UESC:
                begin
                    case (sub)
                        4'd0:    byte_out = CH_BSLASH;
                        4'd1:    byte_out = CH_U;
                        4'd2:    byte_out = hex_char(half[15:12]);
                        4'd3:    byte_out = hex_char(half[11:8]);
                        4'd4:    byte_out = hex_char(half[7:4]);
                        4'd5:    byte_out = hex_char(half[3:0]);
                        default: byte_out = CH_BSLASH;
                    endcase
                end
                JOB_NULL:
                begin
                    err_out = 1'b1;
                    case (body_idx[1:0])
                        2'd0:    byte_out = CH_N;
                        2'd1:    byte_out = CH_U;
                        default: byte_out = CH_L;
                    endcase
                end
                default: byte_out = CH_QUOTE;
            endcase
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_data_reg <= byte_out;
            m_err_reg  <= err_out;
            m_last_reg <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;
    assign m_tlast  = m_last_reg;

    a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last) |=> (m_tvalid && m_tlast))
        else $error("job end did not give a last beat");

    a_err_text: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> ((m_tdata == CH_N) || (m_tdata == CH_U) || (m_tdata == CH_L)))
        else $error("error beat outside null text");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (idx_reg < total_len))
        else $error("byte index beyond job length");

endmodule

`default_nettype wire

/* rtl/core/json_string_escape_encoder.sv */
// json string escape encoder
//
// s_* channel: one beat per input item. s_tdata carries the string byte,
// s_tuser is 1 for the end-of-string item (its s_tdata is ignored).
// m_* channel: one beat per output byte of quoted json text. m_tuser marks
// the four bytes of the null text sent on invalid utf-8, m_tlast marks the
// final byte caused by one input item. Items that cause no output (bytes held
// inside a multibyte sequence, dropped bytes) give no beat.
// cfg_* channel: register writes, always ready; index 0 is simple_mode,
// index 1 is unescaped_unicode. Write only while the block is idle.
//
// The first byte of an item is registered in the job queue and then in the
// output register before it appears on m_*. The output side sends one byte
// per cycle while m_tready allows, and an item expands to 1 to 12 bytes;
// input is taken one per cycle while the job queue (QUEUE_DEPTH entries)
// has room.
// A stalled receiver holds the output register, fills the queue and then
// lowers s_tready. Reset clears the string state, the queue and both
// registers; no string is open afterwards.
`default_nettype none

module json_string_escape_encoder import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tuser,   // cmd
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tuser,   // null_mark
    output logic            m_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic       cfg_data
);

    logic simple_mode_reg;
    logic unescaped_reg;

    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            simple_mode_reg <= 1'b0;
            unescaped_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_SIMPLE_MODE)
            begin
                simple_mode_reg <= cfg_data;
            end
            if (cfg_index == CFG_UNESCAPED_UNICODE)
            begin
                unescaped_reg <= cfg_data;
            end
        end
    end

    jse_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .simple_mode       (simple_mode_reg),
        .unescaped_unicode (unescaped_reg),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .in_cmd            (s_tuser),
        .in_byte           (s_tdata),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_job          (push_job)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    jse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
